/* rtl/lz_pkg.sv */
`default_nettype none
package lz_pkg;
    localparam int WINDOW    = 1024;
    localparam int MAX_MATCH = 32;

    localparam int IDX_W  = $clog2(WINDOW);          // cell index
    localparam int FILL_W = $clog2(WINDOW + 1);      // history fill / offset
    localparam int LEN_W  = $clog2(MAX_MATCH + 1);   // lengths, lookahead fill
    localparam int K_W    = $clog2(MAX_MATCH);       // lookahead index
    localparam int MM_W   = 7;                       // min_match register
    localparam int OFF_W  = 11;                      // match_offset port

    localparam logic [MM_W-1:0] MIN_MATCH_RST = MM_W'(3);

    // data handed from one cell to the next
    typedef struct packed {
        logic [7:0]        hist;
        logic [7:0]        cmp;
        logic              cmp_v;
        logic [LEN_W-1:0]  red_len;
        logic [FILL_W-1:0] red_off;
    } t_link;

    // broadcast controls from the sequencer
    typedef struct packed {
        logic              push;
        logic              load;
        logic              step;
        logic              red;
        logic [7:0]        la_byte;
        logic              la_ok;
        logic [FILL_W-1:0] fill;
    } t_cell_ctl;
endpackage
`default_nettype wire

/* rtl/lz77_greedy_compressor.sv */
// Bytes that cause no token are taken at one per cycle.
// A token passes through the cell row in a load, a compare and a reduce phase,
// then an output state that holds while i_stall is high, then one push step per
// byte consumed. Input is stalled meanwhile.
// Reset (synchronous, i_rst_n low) empties history and lookahead, min_match = 3.
`default_nettype none
module lz77_greedy_compressor import lz_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_byte,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_is_match,
    output logic [7:0]             o_literal,
    output logic [OFF_W-1:0]       o_match_offset,
    output logic [5:0]             o_match_length,
    output logic                   o_last_token,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [MM_W-1:0]   i_min_match
);
    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_CMP, S_RED, S_OUT, S_PUSH} t_state;

    t_state            r_state;
    logic [MM_W-1:0]   r_min_match;
    logic [7:0]        r_la [MAX_MATCH];
    logic [LEN_W-1:0]  r_la_fill;
    logic [FILL_W-1:0] r_h_fill;
    logic              r_flush;
    logic [K_W-1:0]    r_k;
    logic [FILL_W-1:0] r_r;
    logic [LEN_W-1:0]  r_plen;

    t_cell_ctl         ctl;
    t_link             links [WINDOW+1];
    logic              in_acc;
    logic [LEN_W-1:0]  n_fill;
    logic [MM_W-1:0]   thr;
    logic              is_m;
    logic [LEN_W-1:0]  tok_len;
    t_link             best;

    assign in_acc      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign n_fill      = (r_la_fill < LEN_W'(MAX_MATCH)) ? r_la_fill + LEN_W'(1) : r_la_fill;

    assign best    = links[WINDOW];
    assign thr     = (r_min_match == '0) ? MM_W'(1) : r_min_match;
    assign is_m    = {{(MM_W-LEN_W){1'b0}}, best.red_len} >= thr;
    assign tok_len = is_m ? best.red_len : LEN_W'(1);

    always_comb begin
        ctl.push    = (r_state == S_PUSH);
        ctl.load    = (r_state == S_LOAD);
        ctl.step    = (r_state == S_CMP);
        ctl.red     = (r_state == S_RED);
        ctl.la_byte = r_la[r_k];
        ctl.la_ok   = {1'b0, r_k} < r_la_fill;
        ctl.fill    = r_h_fill;
    end

    // cell 0 input: the byte being pushed, no compare data, empty reduction
    assign links[0].hist    = r_la[0];
    assign links[0].cmp     = 8'd0;
    assign links[0].cmp_v   = 1'b0;
    assign links[0].red_len = '0;
    assign links[0].red_off = '0;

    for (genvar gi = 0; gi < WINDOW; gi++) begin : g_cell
        lz_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_index (IDX_W'(gi)),
            .i_prev  (links[gi]),
            .o_link  (links[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min_match <= MIN_MATCH_RST;
            r_la_fill   <= '0;
            r_h_fill    <= '0;
            r_flush     <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_match <= i_min_match;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_la_fill < LEN_W'(MAX_MATCH)) begin
                            r_la[r_la_fill[K_W-1:0]] <= i_data_byte;
                        end
                        r_la_fill <= n_fill;
                        r_flush   <= i_last_byte;
                        if (i_last_byte || n_fill == LEN_W'(MAX_MATCH)) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_k     <= '0;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_k <= r_k + K_W'(1);
                    if (r_k == K_W'(MAX_MATCH - 1)) begin
                        r_r     <= '0;
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    // the last cell settles once the reduction has rippled through every cell
                    r_r <= r_r + FILL_W'(1);
                    if (r_r == FILL_W'(WINDOW)) begin
                        o_valid        <= 1'b1;
                        o_is_match     <= is_m;
                        o_literal      <= is_m ? 8'd0 : r_la[0];
                        o_match_offset <= is_m ? OFF_W'(best.red_off) : '0;
                        o_match_length <= 6'(tok_len);
                        o_last_token   <= r_flush && (r_la_fill == tok_len);
                        r_plen         <= tok_len;
                        r_state        <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    for (int j = 0; j < MAX_MATCH - 1; j++) begin
                        r_la[j] <= r_la[j+1];
                    end
                    r_plen <= r_plen - LEN_W'(1);
                    if (r_plen == LEN_W'(1) && r_flush && r_la_fill == LEN_W'(1)) begin
                        r_h_fill  <= '0;
                        r_la_fill <= '0;
                        r_flush   <= 1'b0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_la_fill <= r_la_fill - LEN_W'(1);
                        if (r_h_fill < FILL_W'(WINDOW)) begin
                            r_h_fill <= r_h_fill + FILL_W'(1);
                        end
                        if (r_plen == LEN_W'(1)) begin
                            r_state <= r_flush ? S_LOAD : S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/lz_cell.sv */
`default_nettype none
module lz_cell import lz_pkg::*; (
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire t_link            i_prev,
    output t_link                 o_link
);
    logic [7:0]        r_hist;
    logic [7:0]        r_cmp;
    logic              r_cmp_v;
    logic              r_alive;
    logic [LEN_W-1:0]  r_cnt;
    logic [LEN_W-1:0]  r_red_len;
    logic [FILL_W-1:0] r_red_off;
    logic [FILL_W-1:0] own_off;
    logic              in_hist;

    assign own_off = {1'b0, i_index} + FILL_W'(1);
    assign in_hist = {1'b0, i_index} < i_ctl.fill;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_hist <= i_prev.hist;
        end
        if (i_ctl.load) begin
            r_cmp     <= r_hist;
            r_cmp_v   <= in_hist;
            r_alive   <= in_hist;
            r_cnt     <= '0;
            r_red_len <= '0;
            r_red_off <= '0;
        end
        if (i_ctl.step) begin
            // compare bytes slide one cell per step toward larger offsets
            r_cmp   <= i_prev.cmp;
            r_cmp_v <= i_prev.cmp_v;
            if (r_alive && r_cmp_v && i_ctl.la_ok && r_cmp == i_ctl.la_byte) begin
                r_cnt <= r_cnt + LEN_W'(1);
            end else begin
                r_alive <= 1'b0;
            end
        end
        if (i_ctl.red) begin
            // >= : equal length at a larger offset wins
            if (r_cnt >= i_prev.red_len) begin
                r_red_len <= r_cnt;
                r_red_off <= own_off;
            end else begin
                r_red_len <= i_prev.red_len;
                r_red_off <= i_prev.red_off;
            end
        end
    end

    assign o_link.hist    = r_hist;
    assign o_link.cmp     = r_cmp;
    assign o_link.cmp_v   = r_cmp_v;
    assign o_link.red_len = r_red_len;
    assign o_link.red_off = r_red_off;
endmodule
`default_nettype wire
